### hw/rtl/multi_channel_deadline_timer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deadline timer
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define MCDT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define MCDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mcdt_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer package
// Field widths, command and status codes, sequencer states and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mcdt_pkg;

  localparam int TIME_W     = 64;
  localparam int PERIOD_W   = 32;
  localparam int REM_W      = 32;
  localparam int SLOT_ID_W  = 4;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int MAX_FIRES  = 16;
  localparam int FIRE_CNT_W = 5;

  localparam logic [TIME_W-1:0] DEADLINE_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [REM_W-1:0]  REM_ALL_ONES = 32'hffff_ffff;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_START  = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_SETP   = 3'd4,
    KIND_QUERY  = 3'd5,
    KIND_TICK   = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_IN_USE = 2'd2,
    STAT_BAD_KIND   = 2'd3
  } status_t;

  typedef enum logic {
    ALU_DUE = 1'b0,
    ALU_REM = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_CMD_ALU,
    S_CMD_WR,
    S_SCAN,
    S_EMIT_MID,
    S_FIRE_RD,
    S_FIRE_ALU,
    S_FIRE_WR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/mcdt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/mcdt_alu.sv
// ----------------------------------------------------------------------------
// Deadline timer arithmetic unit
// One shared 65-bit adder: saturated reload deadline or saturated remaining
// time, result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mcdt_alu import mcdt_pkg::*; (
  input  wire logic              clk,
  input  wire alu_op_t           op,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic [TIME_W-1:0] opnd,
  output logic      [TIME_W-1:0] res
);

  logic [PERIOD_W-1:0] per_eff;
  logic [TIME_W-1:0]   add_a;
  logic [TIME_W-1:0]   add_b;
  logic                add_cin;
  logic [TIME_W:0]     sum;
  logic                now_sat;
  logic [TIME_W-1:0]   res_nxt;
  logic [TIME_W-1:0]   res_r;

  always_comb begin
    // zero period behaves as one
    per_eff = (opnd[PERIOD_W-1:0] == '0) ? PERIOD_W'(1) : opnd[PERIOD_W-1:0];
    now_sat = now[TIME_W-1] | (&now[TIME_W-2:0]);
    add_a   = now;
    add_b   = {{(TIME_W-PERIOD_W){1'b0}}, per_eff};
    add_cin = 1'b0;
    unique case (op)
      ALU_DUE: begin
        add_a   = now;
        add_b   = {{(TIME_W-PERIOD_W){1'b0}}, per_eff};
        add_cin = 1'b0;
      end
      ALU_REM: begin
        // deadline - now as deadline + ~now + 1
        add_a   = opnd;
        add_b   = ~now;
        add_cin = 1'b1;
      end
    endcase
    sum = {1'b0, add_a} + {1'b0, add_b} + (TIME_W+1)'(add_cin);

    res_nxt = '0;
    unique case (op)
      ALU_DUE: begin
        // anything above 2^63-1 sets bit 63 or the carry
        if (now_sat || sum[TIME_W] || sum[TIME_W-1]) begin
          res_nxt = DEADLINE_MAX;
        end else begin
          res_nxt = sum[TIME_W-1:0];
        end
      end
      ALU_REM: begin
        // no carry: deadline below now; zero difference: due now
        if (!sum[TIME_W] || (sum[TIME_W-1:0] == '0)) begin
          res_nxt = '0;
        end else if (|sum[TIME_W-1:REM_W]) begin
          res_nxt = {{(TIME_W-REM_W){1'b0}}, REM_ALL_ONES};
        end else begin
          res_nxt = {{(TIME_W-REM_W){1'b0}}, sum[REM_W-1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

### hw/rtl/multi_channel_deadline_timer.sv
// ----------------------------------------------------------------------------
// Multi-channel deadline timer
// Pool of timer slots on a 64-bit tick counter with create, delete, start,
// stop, set-period, query and tick commands; expiries reported in deadline
// order.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_stall  | kind, slot_id, period, one_shot,
//          |           |                    | start_now
//  out_    | output    | out_valid/out_stall| result_slot, status, remaining,
//          |           |                    | fired, last
//
//  Create walks the in-use flags for a free slot. A tick scans every slot,
//  and scans again after each expiry until none is due or it reaches the
//  cap of 16 fires. The slot scan reads one deadline per cycle from the
//  single read port of the deadline RAM.
//  Reset clears the time counter and the in-use and running flags; deadline
//  and period RAMs need no clearing.
//  A stalled output holds the sequencer at the point where it hands over the
//  next transaction; in_stall is high from acceptance until the last result
//  is registered.
//
`default_nettype none

module multi_channel_deadline_timer import mcdt_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command transactions
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [KIND_W-1:0]    in_kind,
  input  wire logic [SLOT_ID_W-1:0] in_slot_id,
  input  wire logic [PERIOD_W-1:0]  in_period,
  input  wire logic                 in_one_shot,
  input  wire logic                 in_start_now,
  // result transactions
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [SLOT_ID_W-1:0]      out_result_slot,
  output logic [STATUS_W-1:0]       out_status,
  output logic [REM_W-1:0]          out_remaining,
  output logic                      out_fired,
  output logic                      out_last
);

  `include "multi_channel_deadline_timer_assert.svh"

  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int IDW    = (SLOT_W > SLOT_ID_W) ? SLOT_W : SLOT_ID_W;

  // Low four bits of a slot index, zero-extended first for narrow pools.
  function automatic logic [SLOT_ID_W-1:0] slot4(input logic [SLOT_W-1:0] idx);
    logic [IDW-1:0] ext;
    ext = IDW'(idx);
    return ext[SLOT_ID_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                 state_r, state_nxt;

  // latched command
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [SLOT_ID_W-1:0]   sid_r, sid_nxt;
  logic [PERIOD_W-1:0]    per_r, per_nxt;
  logic                   once_in_r, once_in_nxt;
  logic                   go_r, go_nxt;

  // timer state
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [TIMER_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [TIMER_SLOTS-1:0] running_r, running_nxt;
  logic [TIMER_SLOTS-1:0] once_r, once_nxt;
  logic [TIMER_SLOTS-1:0] done_r, done_nxt;

  // sequencer working registers
  logic [SLOT_W-1:0]      tgt_r, tgt_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   eval_vld_r, eval_vld_nxt;
  logic [SLOT_W-1:0]      eval_idx_r, eval_idx_nxt;
  logic                   best_vld_r, best_vld_nxt;
  logic [SLOT_W-1:0]      best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]      best_dl_r, best_dl_nxt;
  logic [FIRE_CNT_W-1:0]  fire_cnt_r, fire_cnt_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0]      pend_slot_r, pend_slot_nxt;

  // final result of the current command
  logic [SLOT_ID_W-1:0]   resp_slot_r, resp_slot_nxt;
  status_t                resp_status_r, resp_status_nxt;
  logic [REM_W-1:0]       resp_rem_r, resp_rem_nxt;
  logic                   resp_fired_r, resp_fired_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [SLOT_ID_W-1:0]   out_slot_r, out_slot_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [REM_W-1:0]       out_rem_r, out_rem_nxt;
  logic                   out_fired_r, out_fired_nxt;
  logic                   out_last_r, out_last_nxt;

  // --------------------------------------------------------------------------
  // RAM and ALU hookup
  // --------------------------------------------------------------------------
  logic                   dl_we;
  logic [SLOT_W-1:0]      dl_waddr;
  logic [TIME_W-1:0]      dl_wdata;
  logic [SLOT_W-1:0]      dl_raddr;
  logic [TIME_W-1:0]      dl_rdata;
  logic                   pr_we;
  logic [SLOT_W-1:0]      pr_waddr;
  logic [PERIOD_W-1:0]    pr_wdata;
  logic [SLOT_W-1:0]      pr_raddr;
  logic [PERIOD_W-1:0]    pr_rdata;
  alu_op_t                alu_op;
  logic [TIME_W-1:0]      alu_opnd;
  logic [TIME_W-1:0]      alu_res;

  mcdt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TIMER_SLOTS)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  mcdt_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (TIMER_SLOTS)
  ) u_period_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  mcdt_alu u_alu (
    .clk  (clk),
    .op   (alu_op),
    .now  (now_r),
    .opnd (alu_opnd),
    .res  (alu_res)
  );

  // --------------------------------------------------------------------------
  // Shared decode
  // --------------------------------------------------------------------------
  logic [IDW-1:0]    sid_ext;
  logic              sid_in_range;
  logic [SLOT_W-1:0] sid_idx;
  logic              sid_valid;
  logic              in_accept;
  logic              out_free;
  logic              find_free;
  logic              find_last;
  logic              scan_issuing;
  logic              scan_end;
  logic              eval_cand;
  logic              fire_limit;

  assign sid_ext      = IDW'(sid_r);
  assign sid_in_range = {1'b0, sid_ext} < (IDW+1)'(TIMER_SLOTS);
  assign sid_idx      = sid_ext[SLOT_W-1:0];
  assign sid_valid    = sid_in_range && in_use_r[sid_idx];

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // create: walk the in-use flags from slot 0 up
  assign find_free = !in_use_r[issue_r[SLOT_W-1:0]];
  assign find_last = (issue_r == CNT_W'(TIMER_SLOTS - 1));

  // tick: address goes out in the cycle before its compare
  assign scan_issuing = (issue_r < CNT_W'(TIMER_SLOTS));
  assign scan_end     = !scan_issuing && !eval_vld_r;
  assign eval_cand    = eval_vld_r && in_use_r[eval_idx_r] && running_r[eval_idx_r] &&
                        !done_r[eval_idx_r] && (dl_rdata <= now_r);

  assign fire_limit = (fire_cnt_r == FIRE_CNT_W'(MAX_FIRES - 1));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (kind_r)
          KIND_CREATE: state_nxt = S_FIND;
          KIND_DELETE,
          KIND_STOP:   state_nxt = S_RESP;
          KIND_START:  state_nxt = sid_valid ? S_CMD_ALU : S_RESP;
          KIND_SETP,
          KIND_QUERY:  state_nxt = (sid_valid && running_r[sid_idx]) ? S_CMD_ALU : S_RESP;
          KIND_TICK:   state_nxt = S_SCAN;
          default:     state_nxt = S_RESP;
        endcase
      end
      S_FIND: begin
        if (find_free) begin
          state_nxt = S_CMD_ALU;
        end else if (find_last) begin
          state_nxt = S_RESP;
        end
      end
      S_CMD_ALU: state_nxt = S_CMD_WR;
      S_CMD_WR:  state_nxt = S_RESP;
      S_SCAN: begin
        if (scan_end) begin
          if (!best_vld_r) begin
            state_nxt = S_RESP;
          end else if (pend_vld_r) begin
            state_nxt = S_EMIT_MID;
          end else begin
            state_nxt = S_FIRE_RD;
          end
        end
      end
      S_EMIT_MID: begin
        if (out_free) begin
          state_nxt = S_FIRE_RD;
        end
      end
      S_FIRE_RD:  state_nxt = S_FIRE_ALU;
      S_FIRE_ALU: state_nxt = S_FIRE_WR;
      S_FIRE_WR:  state_nxt = fire_limit ? S_RESP : S_SCAN;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    kind_nxt        = kind_r;
    sid_nxt         = sid_r;
    per_nxt         = per_r;
    once_in_nxt     = once_in_r;
    go_nxt          = go_r;
    now_nxt         = now_r;
    in_use_nxt      = in_use_r;
    running_nxt     = running_r;
    once_nxt        = once_r;
    done_nxt        = done_r;
    tgt_nxt         = tgt_r;
    issue_nxt       = issue_r;
    eval_vld_nxt    = eval_vld_r;
    eval_idx_nxt    = eval_idx_r;
    best_vld_nxt    = best_vld_r;
    best_idx_nxt    = best_idx_r;
    best_dl_nxt     = best_dl_r;
    fire_cnt_nxt    = fire_cnt_r;
    pend_vld_nxt    = pend_vld_r;
    pend_slot_nxt   = pend_slot_r;
    resp_slot_nxt   = resp_slot_r;
    resp_status_nxt = resp_status_r;
    resp_rem_nxt    = resp_rem_r;
    resp_fired_nxt  = resp_fired_r;

    dl_we    = 1'b0;
    dl_waddr = tgt_r;
    dl_wdata = alu_res;
    dl_raddr = sid_idx;
    pr_we    = 1'b0;
    pr_waddr = tgt_r;
    pr_wdata = per_r;
    pr_raddr = tgt_r;
    alu_op   = ALU_DUE;
    alu_opnd = {{(TIME_W-PERIOD_W){1'b0}}, per_r};

    // the output register drains on its own unless reloaded below
    out_valid_nxt  = out_valid_r && out_stall;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_rem_nxt    = out_rem_r;
    out_fired_nxt  = out_fired_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          kind_nxt    = in_kind;
          sid_nxt     = in_slot_id;
          per_nxt     = in_period;
          once_in_nxt = in_one_shot;
          go_nxt      = in_start_now;
        end
      end

      S_DISPATCH: begin
        tgt_nxt         = sid_idx;
        resp_slot_nxt   = sid_r;
        resp_status_nxt = STAT_OK;
        resp_rem_nxt    = '0;
        resp_fired_nxt  = 1'b0;
        unique case (kind_r)
          KIND_CREATE: begin
            issue_nxt = '0;
          end
          KIND_DELETE, KIND_START, KIND_STOP, KIND_SETP, KIND_QUERY: begin
            if (!sid_valid) begin
              resp_status_nxt = STAT_NOT_IN_USE;
            end else begin
              unique case (kind_r)
                KIND_DELETE: begin
                  in_use_nxt[sid_idx]  = 1'b0;
                  running_nxt[sid_idx] = 1'b0;
                end
                KIND_STOP: begin
                  running_nxt[sid_idx] = 1'b0;
                end
                KIND_START: begin
                  pr_raddr = sid_idx;
                end
                KIND_SETP: begin
                  pr_we    = 1'b1;
                  pr_waddr = sid_idx;
                end
                KIND_QUERY: begin
                  dl_raddr = sid_idx;
                  if (!running_r[sid_idx]) begin
                    resp_rem_nxt = REM_ALL_ONES;
                  end
                end
                default: begin
                end
              endcase
            end
          end
          KIND_TICK: begin
            // advance time, then arm a fresh scan
            now_nxt       = now_r + TIME_W'(1);
            done_nxt      = '0;
            fire_cnt_nxt  = '0;
            pend_vld_nxt  = 1'b0;
            issue_nxt     = '0;
            eval_vld_nxt  = 1'b0;
            best_vld_nxt  = 1'b0;
            resp_slot_nxt = '0;
          end
          default: begin
            resp_status_nxt = STAT_BAD_KIND;
          end
        endcase
      end

      S_FIND: begin
        if (find_free) begin
          tgt_nxt = issue_r[SLOT_W-1:0];
        end else if (find_last) begin
          resp_slot_nxt   = '0;
          resp_status_nxt = STAT_FULL;
        end else begin
          issue_nxt = issue_r + CNT_W'(1);
        end
      end

      S_CMD_ALU: begin
        unique case (kind_r)
          KIND_START: begin
            alu_op   = ALU_DUE;
            alu_opnd = {{(TIME_W-PERIOD_W){1'b0}}, pr_rdata};
          end
          KIND_QUERY: begin
            alu_op   = ALU_REM;
            alu_opnd = dl_rdata;
          end
          default: begin
            // create and set period reload from the command's own period
            alu_op   = ALU_DUE;
            alu_opnd = {{(TIME_W-PERIOD_W){1'b0}}, per_r};
          end
        endcase
      end

      S_CMD_WR: begin
        unique case (kind_r)
          KIND_CREATE: begin
            pr_we              = 1'b1;
            dl_we              = 1'b1;
            once_nxt[tgt_r]    = once_in_r;
            running_nxt[tgt_r] = go_r;
            in_use_nxt[tgt_r]  = 1'b1;
            resp_slot_nxt      = slot4(tgt_r);
          end
          KIND_START: begin
            dl_we              = 1'b1;
            running_nxt[tgt_r] = 1'b1;
          end
          KIND_SETP: begin
            dl_we = 1'b1;
          end
          KIND_QUERY: begin
            resp_rem_nxt = alu_res[REM_W-1:0];
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        dl_raddr     = issue_r[SLOT_W-1:0];
        eval_vld_nxt = scan_issuing;
        eval_idx_nxt = issue_r[SLOT_W-1:0];
        if (scan_issuing) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        // strict less-than keeps the lower slot on equal deadlines
        if (eval_cand && (!best_vld_r || (dl_rdata < best_dl_r))) begin
          best_vld_nxt = 1'b1;
          best_idx_nxt = eval_idx_r;
          best_dl_nxt  = dl_rdata;
        end
        if (scan_end) begin
          if (best_vld_r) begin
            tgt_nxt = best_idx_r;
          end else begin
            // close the tick: held expiry, or the quiet result
            resp_slot_nxt   = pend_vld_r ? slot4(pend_slot_r) : '0;
            resp_status_nxt = STAT_OK;
            resp_rem_nxt    = '0;
            resp_fired_nxt  = pend_vld_r;
          end
        end
      end

      S_EMIT_MID: begin
        // another timer is due, so the held expiry is not the last one
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slot4(pend_slot_r);
          out_status_nxt = STAT_OK;
          out_rem_nxt    = '0;
          out_fired_nxt  = 1'b1;
          out_last_nxt   = 1'b0;
          pend_vld_nxt   = 1'b0;
        end
      end

      S_FIRE_RD: begin
        pr_raddr = tgt_r;
      end

      S_FIRE_ALU: begin
        alu_op   = ALU_DUE;
        alu_opnd = {{(TIME_W-PERIOD_W){1'b0}}, pr_rdata};
      end

      S_FIRE_WR: begin
        done_nxt[tgt_r] = 1'b1;
        if (once_r[tgt_r]) begin
          running_nxt[tgt_r] = 1'b0;
        end else begin
          dl_we = 1'b1;
        end
        fire_cnt_nxt  = fire_cnt_r + FIRE_CNT_W'(1);
        pend_vld_nxt  = 1'b1;
        pend_slot_nxt = tgt_r;
        if (fire_limit) begin
          resp_slot_nxt   = slot4(tgt_r);
          resp_status_nxt = STAT_OK;
          resp_rem_nxt    = '0;
          resp_fired_nxt  = 1'b1;
        end else begin
          issue_nxt    = '0;
          eval_vld_nxt = 1'b0;
          best_vld_nxt = 1'b0;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = resp_slot_r;
          out_status_nxt = resp_status_r;
          out_rem_nxt    = resp_rem_r;
          out_fired_nxt  = resp_fired_r;
          out_last_nxt   = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Register update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      in_use_r    <= '0;
      running_r   <= '0;
      done_r      <= '0;
      issue_r     <= '0;
      eval_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      fire_cnt_r  <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      in_use_r    <= in_use_nxt;
      running_r   <= running_nxt;
      done_r      <= done_nxt;
      issue_r     <= issue_nxt;
      eval_vld_r  <= eval_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    sid_r         <= sid_nxt;
    per_r         <= per_nxt;
    once_in_r     <= once_in_nxt;
    go_r          <= go_nxt;
    once_r        <= once_nxt;
    tgt_r         <= tgt_nxt;
    eval_idx_r    <= eval_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_dl_r     <= best_dl_nxt;
    pend_slot_r   <= pend_slot_nxt;
    resp_slot_r   <= resp_slot_nxt;
    resp_status_r <= resp_status_nxt;
    resp_rem_r    <= resp_rem_nxt;
    resp_fired_r  <= resp_fired_nxt;
    out_slot_r    <= out_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_rem_r     <= out_rem_nxt;
    out_fired_r   <= out_fired_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_status      = out_status_r;
  assign out_remaining   = out_rem_r;
  assign out_fired       = out_fired_r;
  assign out_last        = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MCDT_ASSERT_ALWAYS(a_running_in_use, clk, rst_n, (running_r & ~in_use_r) == '0, "running slot not in use")
  `MCDT_ASSERT_ALWAYS(a_fire_limit, clk, rst_n, fire_cnt_r <= FIRE_CNT_W'(MAX_FIRES), "too many expiries on one tick")
  `MCDT_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && !in_stall, state_r == S_DISPATCH, "accepted command not dispatched")
  `MCDT_ASSERT_NEXT(a_resp_last, clk, rst_n, state_r == S_RESP && out_free, state_r == S_IDLE && out_valid_r && out_last_r, "final result not marked last")

endmodule

`default_nettype wire

### sim/timer_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer result checker
// Watches the command and result channels. Keeps its own copy of the timer
// pool, predicts every result of each accepted command and compares the
// results that come out, in order, field by field.
// ----------------------------------------------------------------------------
module timer_result_checker import mcdt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [SLOT_ID_W-1:0] in_slot_id,
  input  logic [PERIOD_W-1:0]  in_period,
  input  logic                 in_one_shot,
  input  logic                 in_start_now,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SLOT_ID_W-1:0] out_result_slot,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic [REM_W-1:0]     out_remaining,
  input  logic                 out_fired,
  input  logic                 out_last,
  output int                   mismatch_count,
  output int                   results_waiting,
  output int                   results_checked,
  output int                   expiries_seen
);

  typedef struct packed {
    logic [SLOT_ID_W-1:0] slot;
    status_t              status;
    logic [REM_W-1:0]     remaining;
    logic                 fired;
    logic                 last;
  } timer_result_t;

  logic [TIME_W-1:0]   now_ticks;
  logic [TIME_W-1:0]   slot_deadline [SLOTS];
  logic [PERIOD_W-1:0] slot_reload [SLOTS];
  logic [SLOTS-1:0]    in_use;
  logic [SLOTS-1:0]    running;
  logic [SLOTS-1:0]    one_shot_mode;

  timer_result_t pending_results [$];
  int            mismatches;
  int            checked;
  int            expiries;

  function automatic timer_result_t make_result(logic [SLOT_ID_W-1:0] slot, status_t st,
                                                logic [REM_W-1:0] rem, logic fired,
                                                logic last);
    timer_result_t r;
    r.slot      = slot;
    r.status    = st;
    r.remaining = rem;
    r.fired     = fired;
    r.last      = last;
    return r;
  endfunction

  // Next deadline from now; a zero period counts as one, clamp at the ceiling.
  function automatic logic [TIME_W-1:0] reload_deadline(logic [PERIOD_W-1:0] per);
    logic [TIME_W-1:0] step;
    step = (per == '0) ? 64'd1 : {32'd0, per};
    if (now_ticks >= DEADLINE_MAX || DEADLINE_MAX - now_ticks < step)
      return DEADLINE_MAX;
    return now_ticks + step;
  endfunction

  task automatic reset_pool();
    now_ticks     = '0;
    in_use        = '0;
    running       = '0;
    one_shot_mode = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_deadline[i] = '0;
      slot_reload[i]   = '0;
    end
    pending_results.delete();
    mismatches = 0;
    checked    = 0;
    expiries   = 0;
  endtask

  task automatic apply_command(input logic [KIND_W-1:0] kind,
                               input logic [SLOT_ID_W-1:0] sid,
                               input logic [PERIOD_W-1:0] per,
                               input logic once, input logic go);
    logic [REM_W-1:0]  rem;
    logic [TIME_W-1:0] ahead;
    logic [SLOTS-1:0]  done;
    logic              addressed;
    int                fire_slot [MAX_FIRES];
    int                cnt;
    int                best;
    int                free_slot;
    addressed = (sid < SLOTS) && in_use[sid];
    case (kind)
      KIND_CREATE: begin
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!in_use[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          pending_results.push_back(make_result('0, STAT_FULL, '0, 1'b0, 1'b1));
        end else begin
          slot_reload[free_slot]   = per;
          one_shot_mode[free_slot] = once;
          slot_deadline[free_slot] = reload_deadline(per);
          running[free_slot]       = go;
          in_use[free_slot]        = 1'b1;
          pending_results.push_back(make_result(SLOT_ID_W'(free_slot), STAT_OK, '0, 1'b0,
                                                1'b1));
        end
      end
      KIND_DELETE, KIND_START, KIND_STOP, KIND_SETP, KIND_QUERY: begin
        if (!addressed) begin
          pending_results.push_back(make_result(sid, STAT_NOT_IN_USE, '0, 1'b0, 1'b1));
        end else begin
          rem = '0;
          case (kind)
            KIND_DELETE: begin
              in_use[sid]  = 1'b0;
              running[sid] = 1'b0;
            end
            KIND_START: begin
              running[sid]       = 1'b1;
              slot_deadline[sid] = reload_deadline(slot_reload[sid]);
            end
            KIND_STOP: running[sid] = 1'b0;
            KIND_SETP: begin
              slot_reload[sid] = per;
              if (running[sid]) slot_deadline[sid] = reload_deadline(per);
            end
            default: begin
              if (!running[sid]) begin
                rem = REM_ALL_ONES;
              end else if (slot_deadline[sid] > now_ticks) begin
                ahead = slot_deadline[sid] - now_ticks;
                rem   = (ahead > {32'd0, REM_ALL_ONES}) ? REM_ALL_ONES : ahead[REM_W-1:0];
              end
            end
          endcase
          pending_results.push_back(make_result(sid, STAT_OK, rem, 1'b0, 1'b1));
        end
      end
      KIND_TICK: begin
        now_ticks = now_ticks + 1'b1;
        done      = '0;
        cnt       = 0;
        // Fire due timers earliest deadline first, lower slot on a tie.
        while (cnt < MAX_FIRES) begin
          best = -1;
          for (int i = 0; i < SLOTS; i++)
            if (in_use[i] && running[i] && !done[i] && slot_deadline[i] <= now_ticks)
              if (best < 0 || slot_deadline[i] < slot_deadline[best]) best = i;
          if (best < 0) break;
          done[best] = 1'b1;
          if (one_shot_mode[best]) running[best] = 1'b0;
          else slot_deadline[best] = reload_deadline(slot_reload[best]);
          fire_slot[cnt] = best;
          cnt++;
        end
        if (cnt == 0) begin
          pending_results.push_back(make_result('0, STAT_OK, '0, 1'b0, 1'b1));
        end else begin
          for (int k = 0; k < cnt; k++)
            pending_results.push_back(make_result(SLOT_ID_W'(fire_slot[k]), STAT_OK, '0,
                                                  1'b1, k == cnt - 1));
        end
      end
      default: pending_results.push_back(make_result(sid, STAT_BAD_KIND, '0, 1'b0, 1'b1));
    endcase
  endtask

  task automatic check_result();
    timer_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no command waiting: slot %0d status %0d", out_result_slot,
             out_status);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (out_result_slot !== want.slot) begin
        $error("result_slot: expected %0d, actual %0d", want.slot, out_result_slot);
        mismatches++;
      end
      if (out_status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, out_status);
        mismatches++;
      end
      if (out_remaining !== want.remaining) begin
        $error("remaining: expected %0d, actual %0d", want.remaining, out_remaining);
        mismatches++;
      end
      if (out_fired !== want.fired) begin
        $error("fired: expected %0d, actual %0d", want.fired, out_fired);
        mismatches++;
      end
      if (out_last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, out_last);
        mismatches++;
      end
      if (want.fired) expiries++;
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_pool();
    end else begin
      if (in_valid && !in_stall)
        apply_command(in_kind, in_slot_id, in_period, in_one_shot, in_start_now);
      if (out_valid && !out_stall) check_result();
    end
    mismatch_count  <= mismatches;
    results_waiting <= pending_results.size();
    results_checked <= checked;
    expiries_seen   <= expiries;
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer testbench
// Drives command transactions into the timer pool: a directed opening that
// walks every command, the error statuses and a full pool firing on one
// tick, then a long random mix dominated by ticks. Both channels idle at
// random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import mcdt_pkg::*;

  localparam int TIMER_SLOTS  = 16;
  localparam int RANDOM_ITEMS = 450;
  // A limit on the whole run, with room for every item to be a crowded tick
  // under heavy output stall, and then some.
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Longer than one fire step of the slot scan, to catch stray results.
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_GAP      = 40;

  // No command decodes to this code.
  localparam logic [KIND_W-1:0] KIND_UNDEFINED = 3'd7;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind      = KIND_TICK;
  logic [SLOT_ID_W-1:0] in_slot_id   = '0;
  logic [PERIOD_W-1:0]  in_period    = '0;
  logic                 in_one_shot  = 1'b0;
  logic                 in_start_now = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [SLOT_ID_W-1:0] out_result_slot;
  logic [STATUS_W-1:0]  out_status;
  logic [REM_W-1:0]     out_remaining;
  logic                 out_fired;
  logic                 out_last;

  int mismatch_count;
  int results_waiting;
  int results_checked;
  int expiries_seen;

  // Idle odds in percent per cycle; the stimulus process moves them between
  // phases.
  int send_pct  = 12;
  int recv_pct  = 86;
  int items_sent = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  multi_channel_deadline_timer #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_slot_id     (in_slot_id),
    .in_period      (in_period),
    .in_one_shot    (in_one_shot),
    .in_start_now   (in_start_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_slot(out_result_slot),
    .out_status     (out_status),
    .out_remaining  (out_remaining),
    .out_fired      (out_fired),
    .out_last       (out_last)
  );

  timer_result_checker #(
    .SLOTS(TIMER_SLOTS)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_slot_id     (in_slot_id),
    .in_period      (in_period),
    .in_one_shot    (in_one_shot),
    .in_start_now   (in_start_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_slot(out_result_slot),
    .out_status     (out_status),
    .out_remaining  (out_remaining),
    .out_fired      (out_fired),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .results_waiting(results_waiting),
    .results_checked(results_checked),
    .expiries_seen  (expiries_seen)
  );

  // Stall the result channel at random, one draw per cycle, so that stalls
  // land on every step of the sequencer's work.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Hang guard: end the run if the results stop coming.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
             results_waiting);
    $display("FAIL multi_channel_deadline_timer");
    $finish;
  end

  // Present one command transaction and hold it until accepted. Call at a
  // rising edge; return at the edge where the transaction is taken. Valid is
  // lowered only when an idle gap follows, so it never toggles within a step.
  task automatic send_command(input logic [KIND_W-1:0] kind,
                              input logic [SLOT_ID_W-1:0] sid,
                              input logic [PERIOD_W-1:0] per,
                              input logic once, input logic go);
    int   gap;
    logic stall_seen;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_slot_id   <= sid;
    in_period    <= per;
    in_one_shot  <= once;
    in_start_now <= go;
    // Sample the stall between edges, where it has settled, so the edge
    // that takes the transaction is known without racing the design.
    forever begin
      @(negedge clk);
      stall_seen = in_stall;
      @(posedge clk);
      if (!stall_seen) break;
    end
    items_sent++;
  endtask

  // Mostly short periods so timers actually expire; a few huge ones and the
  // extremes to toggle the upper bits.
  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 85) return $urandom_range(5, 40);
    if (r < 95) return $urandom;
    return (r < 98) ? 32'hffff_ffff : 32'h8000_0000;
  endfunction

  initial begin
    int                   directed_items;
    int                   r;
    logic [KIND_W-1:0]    kind;

    // Hold reset from time zero, release it at an edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Time starts at zero.
    send_command(KIND_QUERY, 4'd0, '0, 1'b0, 1'b0);             // slot not in use
    send_command(KIND_UNDEFINED, 4'd15, 32'hffff_ffff, 1'b1, 1'b1);
    send_command(KIND_TICK, 4'd0, '0, 1'b0, 1'b0);              // quiet tick
    send_command(KIND_CREATE, 4'd0, 32'd0, 1'b1, 1'b1);         // zero period, one-shot
    send_command(KIND_CREATE, 4'd0, 32'hffff_ffff, 1'b0, 1'b0); // longest period, held
    send_command(KIND_QUERY, 4'd1, '0, 1'b0, 1'b0);             // stopped reads all ones
    send_command(KIND_START, 4'd1, '0, 1'b0, 1'b0);
    send_command(KIND_QUERY, 4'd1, '0, 1'b0, 1'b0);             // full period left
    send_command(KIND_TICK, 4'd0, '0, 1'b0, 1'b0);              // one-shot fires
    send_command(KIND_STOP, 4'd0, '0, 1'b0, 1'b0);              // stop of a stopped timer
    send_command(KIND_SETP, 4'd1, 32'd1, 1'b0, 1'b0);           // reload while running
    send_command(KIND_DELETE, 4'd0, '0, 1'b0, 1'b0);
    send_command(KIND_START, 4'd0, '0, 1'b0, 1'b0);             // deleted slot
    // Fill the pool with period-one timers due together with slot 1.
    repeat (TIMER_SLOTS - 1) send_command(KIND_CREATE, 4'd0, 32'd1, 1'b0, 1'b1);
    send_command(KIND_CREATE, 4'd0, 32'd3, 1'b1, 1'b1);         // pool full
    // Every slot due on the same tick: ties resolve by slot index.
    send_command(KIND_TICK, 4'd0, '0, 1'b0, 1'b0);
    send_command(KIND_TICK, 4'd0, '0, 1'b0, 1'b0);
    directed_items = items_sent;

    // Random mix, ticks about two in five.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_pct = 86;
        recv_pct = 12;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_pct = 0;
        recv_pct = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 38)      kind = KIND_TICK;
      else if (r < 50) kind = KIND_CREATE;
      else if (r < 62) kind = KIND_DELETE;
      else if (r < 69) kind = KIND_START;
      else if (r < 76) kind = KIND_STOP;
      else if (r < 84) kind = KIND_SETP;
      else if (r < 96) kind = KIND_QUERY;
      else             kind = KIND_UNDEFINED;
      send_command(kind, SLOT_ID_W'($urandom_range(0, TIMER_SLOTS - 1)), pick_period(),
                   1'($urandom_range(0, 1)), $urandom_range(0, 99) < 75);
    end

    // Drop valid, wait for every predicted result, then watch a while longer
    // for anything extra.
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d directed) over %0d cycles", items_sent, directed_items,
             cycle_count);
    $display("Checked %0d results, %0d of them timer expiries", results_checked,
             expiries_seen);
    if (mismatch_count == 0) begin
      $display("PASS multi_channel_deadline_timer");
    end else begin
      $display("FAIL multi_channel_deadline_timer");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mcdt_pkg.sv
hw/rtl/mcdt_ram.sv
hw/rtl/mcdt_alu.sv
hw/rtl/multi_channel_deadline_timer.sv
sim/timer_result_checker.sv
sim/testbench.sv
